/* rtl/core/shabs_pkg.sv */
// Shared types, constants and helper functions of the SHA-256 byte stream hasher.
package shabs_pkg;

    typedef logic [31:0]       t_word;
    typedef logic [7:0][31:0]  t_hash;
    typedef logic [15:0][31:0] t_sched;

    localparam logic OP_ABSORB = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    localparam t_word K_ROUND [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam t_word HASH_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic t_word big_sigma0(input t_word x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic t_word big_sigma1(input t_word x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic t_word small_sigma0(input t_word x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic t_word small_sigma1(input t_word x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

endpackage

/* rtl/core/sha256_byte_stream_hasher.sv */
// Top level of the SHA-256 byte stream hasher with its block sequencer.
//
// This block hashes a byte stream with standard SHA-256. Each input transfer
// carries one byte in s_axis_tdata and an operation in s_axis_tuser: 0 absorbs
// the byte, 1 finishes the message (the byte is then ignored). An absorb stores
// the byte; the one that fills a 64-byte block also starts the compression,
// which runs 64 rounds on a single shared round unit at one round per cycle,
// followed by an add state that adds the result into the hash, and the input
// stays not ready until the add is done. A finish pads the pending bytes with
// 0x80, zeros and the 64-bit big-endian bit length, then compresses and adds
// that block before the first digest word appears; when 56 or more bytes are
// pending, the length spills into a second block, and both blocks are
// compressed in turn. The digest then leaves as eight output transfers, H0
// first, word index in the upper bits of tdata and tlast on the eighth word,
// one per cycle while m_axis_tready is high. The input accepts nothing until
// the last digest word is taken, and the hasher then starts a new message from
// the initial hash values. The bit length wraps modulo 2^64.
module sha256_byte_stream_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index, zeros above
    output logic        m_axis_tlast    // last_word
);
    import shabs_pkg::*;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_COMP    = 3'd1;
    localparam logic [2:0] ST_ADD     = 3'd2;
    localparam logic [2:0] ST_FIN_LEN = 3'd3;
    localparam logic [2:0] ST_OUT     = 3'd4;

    logic [2:0]  r_state, n_state;
    logic [2:0]  r_after, n_after;    // where to go once a compression is added back
    logic [5:0]  r_cnt, n_cnt;        // bytes pending in the block
    logic [63:0] r_msg_bits, n_msg_bits;
    logic        r_two, n_two;        // finish needs a second, length-only block
    logic [5:0]  r_round, n_round;
    logic [2:0]  r_idx, n_idx;
    t_sched      r_sched, n_sched;    // block words, later the schedule window
    t_hash       r_vars, n_vars;
    t_hash       r_hash, n_hash;

    t_hash       round_vars;
    t_word       sched_new;
    logic        in_fire;
    logic        out_fire;

    shabs_round u_round (
        .i_round     (r_round),
        .i_vars      (r_vars),
        .i_sched     (r_sched),
        .o_vars      (round_vars),
        .o_sched_new (sched_new)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (r_state == ST_OUT);
    assign out_fire      = m_axis_tvalid && m_axis_tready;

    // The hash words rotate toward index 0 as they are sent, so word 0 is
    // always the one on the bus.
    assign m_axis_tdata = {5'd0, r_idx, r_hash[0]};
    assign m_axis_tlast = (r_idx == 3'd7);

    always_comb begin
        n_state    = r_state;
        n_after    = r_after;
        n_cnt      = r_cnt;
        n_msg_bits = r_msg_bits;
        n_two      = r_two;
        n_round    = r_round;
        n_idx      = r_idx;
        n_sched    = r_sched;
        n_vars     = r_vars;
        n_hash     = r_hash;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    if (s_axis_tuser == OP_ABSORB) begin
                        // Byte 0 of a block is the most significant byte of word 0.
                        for (int p = 0; p < 64; p++) begin
                            if (6'(p) == r_cnt) begin
                                n_sched[p / 4][31 - 8 * (p % 4) -: 8] = s_axis_tdata;
                            end
                        end
                        n_cnt = r_cnt + 6'd1;
                        if (r_cnt == 6'd63) begin
                            n_state = ST_COMP;
                            n_after = ST_IDLE;
                            n_vars  = r_hash;
                            n_round = 6'd0;
                        end
                    end else begin
                        for (int p = 0; p < 64; p++) begin
                            if (6'(p) == r_cnt) begin
                                n_sched[p / 4][31 - 8 * (p % 4) -: 8] = 8'h80;
                            end else if (6'(p) > r_cnt) begin
                                n_sched[p / 4][31 - 8 * (p % 4) -: 8] = 8'h00;
                            end
                        end
                        n_msg_bits = r_msg_bits + {55'd0, r_cnt, 3'd0};
                        n_two      = (r_cnt >= 6'd56);
                        if (r_cnt >= 6'd56) begin
                            n_state = ST_COMP;
                            n_after = ST_FIN_LEN;
                            n_vars  = r_hash;
                            n_round = 6'd0;
                        end else begin
                            n_state = ST_FIN_LEN;
                        end
                    end
                end
            end
            ST_COMP: begin
                n_vars = round_vars;
                for (int j = 0; j < 15; j++) begin
                    n_sched[j] = r_sched[j + 1];
                end
                n_sched[15] = sched_new;
                n_round     = r_round + 6'd1;
                if (r_round == 6'd63) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                for (int i = 0; i < 8; i++) begin
                    n_hash[i] = r_hash[i] + r_vars[i];
                end
                n_state = r_after;
                if (r_after == ST_IDLE) begin
                    n_msg_bits = r_msg_bits + 64'd512;
                end
            end
            ST_FIN_LEN: begin
                // A spilled finish starts a fresh block of zeros before the length.
                if (r_two) begin
                    for (int j = 0; j < 14; j++) begin
                        n_sched[j] = '0;
                    end
                end
                n_sched[14] = r_msg_bits[63:32];
                n_sched[15] = r_msg_bits[31:0];
                n_two       = 1'b0;
                n_state     = ST_COMP;
                n_after     = ST_OUT;
                n_vars      = r_hash;
                n_round     = 6'd0;
            end
            ST_OUT: begin
                if (out_fire) begin
                    // Initial values enter at the top so the hash is restored
                    // after all eight words are sent.
                    for (int i = 0; i < 7; i++) begin
                        n_hash[i] = r_hash[i + 1];
                    end
                    n_hash[7] = HASH_INIT[r_idx];
                    n_idx     = r_idx + 3'd1;
                    if (r_idx == 3'd7) begin
                        n_state    = ST_IDLE;
                        n_cnt      = 6'd0;
                        n_msg_bits = 64'd0;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_after    <= ST_IDLE;
            r_cnt      <= 6'd0;
            r_msg_bits <= 64'd0;
            r_two      <= 1'b0;
            r_idx      <= 3'd0;
            for (int i = 0; i < 8; i++) begin
                r_hash[i] <= HASH_INIT[i];
            end
        end else begin
            r_state    <= n_state;
            r_after    <= n_after;
            r_cnt      <= n_cnt;
            r_msg_bits <= n_msg_bits;
            r_two      <= n_two;
            r_idx      <= n_idx;
            r_hash     <= n_hash;
        end
    end

    always_ff @(posedge i_clk) begin
        r_round <= n_round;
        r_sched <= n_sched;
        r_vars  <= n_vars;
    end

endmodule

/* rtl/core/shabs_round.sv */
// One SHA-256 compression round together with the next message schedule word.
module shabs_round (
    input  logic [5:0]       i_round,
    input  shabs_pkg::t_hash  i_vars,
    input  shabs_pkg::t_sched i_sched,
    output shabs_pkg::t_hash  o_vars,
    output shabs_pkg::t_word  o_sched_new
);
    import shabs_pkg::*;

    t_word t1;
    t_word t2;
    t_word ch;
    t_word maj;

    // Working variables a..h sit at indexes 0..7.
    assign ch  = (i_vars[4] & i_vars[5]) ^ (~i_vars[4] & i_vars[6]);
    assign maj = (i_vars[0] & i_vars[1]) ^ (i_vars[0] & i_vars[2]) ^ (i_vars[1] & i_vars[2]);
    assign t1  = i_vars[7] + big_sigma1(i_vars[4]) + ch + K_ROUND[i_round] + i_sched[0];
    assign t2  = big_sigma0(i_vars[0]) + maj;

    assign o_vars[0] = t1 + t2;
    assign o_vars[1] = i_vars[0];
    assign o_vars[2] = i_vars[1];
    assign o_vars[3] = i_vars[2];
    assign o_vars[4] = i_vars[3] + t1;
    assign o_vars[5] = i_vars[4];
    assign o_vars[6] = i_vars[5];
    assign o_vars[7] = i_vars[6];

    // The window holds W[t..t+15]; this is W[t+16].
    assign o_sched_new = small_sigma1(i_sched[14]) + i_sched[9]
                       + small_sigma0(i_sched[1]) + i_sched[0];

endmodule
